// ----- design/packet_interarrival_histogram_assert.svh -----
// Assertion macros shared by the checker of the interarrival histogram.
`ifndef PACKET_INTERARRIVAL_HISTOGRAM_ASSERT_SVH
`define PACKET_INTERARRIVAL_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define PHIST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PHIST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/phist_pkg.sv -----
// Package of the interarrival histogram: widths, defaults and shared types.
`default_nettype none

package phist_pkg;

    // Field widths.
    localparam int TS_W    = 32;
    localparam int TIME_W  = 64;
    localparam int CNT_W   = 64;
    localparam int SHIFT_W = 6;
    localparam int IDX_W   = 6;

    // Defaults of the top-level parameters.
    localparam int NUM_BUCKETS_DEF     = 64;
    localparam int REPORT_INTERVAL_DEF = 64;

    // A report never carries more beats than this.
    localparam int MAX_REPORT = 64;

    // Bin shift after reset, buckets of roughly 16 ms.
    localparam logic [SHIFT_W-1:0] BIN_SHIFT_RESET = 6'd24;

    typedef logic [TS_W-1:0]    ts_word_t;
    typedef logic [TIME_W-1:0]  stamp_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [IDX_W-1:0]   bucket_idx_t;

endpackage

`default_nettype wire

// ----- design/phist_if.sv -----
// Handshake interfaces for the packet timestamp and report channels.
`default_nettype none

interface phist_in_if;
    logic               valid;
    logic               ready;
    phist_pkg::ts_word_t ts_seconds;
    phist_pkg::ts_word_t ts_nanoseconds;

    modport source (output valid, output ts_seconds, output ts_nanoseconds, input ready);
    modport sink   (input valid, input ts_seconds, input ts_nanoseconds, output ready);
endinterface

interface phist_out_if;
    logic                   valid;
    logic                   ready;
    phist_pkg::bucket_idx_t bucket_index;
    phist_pkg::count_t      bucket_count;
    phist_pkg::count_t      overflow_count;
    logic                   last_bucket;

    modport source (output valid, output bucket_index, output bucket_count,
                    output overflow_count, output last_bucket, input ready);
    modport sink   (input valid, input bucket_index, input bucket_count,
                    input overflow_count, input last_bucket, output ready);
endinterface

`default_nettype wire

// ----- design/packet_interarrival_histogram.sv -----
// A packet is taken in ST_IDLE, or in ST_UPD while the last one is written back; ST_BIN
// picks its bucket and reads the counter, and ST_UPD writes it back incremented. A report
// packet then brings min(NUM_BUCKETS, 64) beats; each registered read is issued once the
// last is loaded and the output register is free. The bucket read-modify-write through
// the counter memory sets the packet rate. After reset a clearing pass zeroes the counter
// memory, during which no packet is taken; configuration writes are accepted throughout.
`default_nettype none

module packet_interarrival_histogram #(
    parameter int NUM_BUCKETS     = phist_pkg::NUM_BUCKETS_DEF,
    parameter int REPORT_INTERVAL = phist_pkg::REPORT_INTERVAL_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire phist_pkg::shift_t cfg_wdata,
    phist_in_if.sink               pkt,
    phist_out_if.source            rpt
);

    localparam int AW    = $clog2(NUM_BUCKETS);
    localparam int REP_N = (NUM_BUCKETS < phist_pkg::MAX_REPORT) ? NUM_BUCKETS
                                                                 : phist_pkg::MAX_REPORT;
    localparam int IW    = $clog2(REP_N);
    localparam int CW    = (REPORT_INTERVAL > 1) ? $clog2(REPORT_INTERVAL) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN,
        ST_UPD,
        ST_DUMP
    } state_t;

    state_t                 state_reg;
    phist_pkg::shift_t      bin_shift_reg;
    phist_pkg::stamp_t      prev_time_reg;
    phist_pkg::stamp_t      delta_reg;
    logic [CW-1:0]          pkt_cnt_reg;
    logic                   report_reg;
    phist_pkg::count_t      ovf_reg;
    logic [AW-1:0]          slot_reg;
    logic                   hit_reg;
    logic [AW-1:0]          clr_idx_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic                   issue_done_reg;
    logic                   rd_pend_reg;
    logic [IW-1:0]          pend_idx_reg;
    logic                   out_valid_reg;
    phist_pkg::bucket_idx_t out_index_reg;
    phist_pkg::count_t      out_count_reg;
    phist_pkg::count_t      out_ovf_reg;
    logic                   out_last_reg;

    phist_pkg::stamp_t      now;
    logic                   in_ready;
    logic                   in_fire;
    logic                   report_next;
    logic                   bin_hit;
    logic [AW-1:0]          bin_slot;
    logic                   out_free;
    logic                   dump_issue;
    logic                   dump_load;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    phist_pkg::count_t      ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    phist_pkg::count_t      ram_rdata;

    // Bucket choice from the registered delta.
    phist_bin #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .AW          (AW)
    ) u_bin (
        .delta (delta_reg),
        .shift (bin_shift_reg),
        .hit   (bin_hit),
        .slot  (bin_slot)
    );

    // Bucket counter store.
    phist_ram #(
        .DEPTH (NUM_BUCKETS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and memory port control.
    always_comb
    begin
        now         = {pkt.ts_seconds, pkt.ts_nanoseconds};
        in_ready    = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && !report_reg);
        in_fire     = pkt.valid && in_ready;
        report_next = (pkt_cnt_reg == CW'(REPORT_INTERVAL - 1));
        out_free    = !out_valid_reg || rpt.ready;
        dump_issue  = (state_reg == ST_DUMP) && !issue_done_reg && !rd_pend_reg && out_free;
        dump_load   = (state_reg == ST_DUMP) && rd_pend_reg;

        ram_re      = ((state_reg == ST_BIN) && bin_hit) || dump_issue;
        ram_raddr   = (state_reg == ST_DUMP) ? AW'(rd_idx_reg) : bin_slot;
        ram_we      = (state_reg == ST_CLEAR) || ((state_reg == ST_UPD) && hit_reg);
        ram_waddr   = (state_reg == ST_CLEAR) ? clr_idx_reg : slot_reg;
        ram_wdata   = (state_reg == ST_CLEAR) ? '0 : ram_rdata + phist_pkg::CNT_W'(1);
    end

    // Sequencer, histogram state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            bin_shift_reg  <= phist_pkg::BIN_SHIFT_RESET;
            prev_time_reg  <= '0;
            pkt_cnt_reg    <= '0;
            report_reg     <= 1'b0;
            ovf_reg        <= '0;
            hit_reg        <= 1'b0;
            clr_idx_reg    <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bin_shift_reg <= cfg_wdata;
            end

            // Take the packet: form the delta and advance the packet counter.
            if (in_fire)
            begin
                delta_reg     <= now - prev_time_reg;
                prev_time_reg <= now;
                report_reg    <= report_next;
                pkt_cnt_reg   <= report_next ? '0 : pkt_cnt_reg + CW'(1);
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                    if (clr_idx_reg == AW'(NUM_BUCKETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_BIN;
                    end
                end
                ST_BIN:
                begin
                    hit_reg   <= bin_hit;
                    slot_reg  <= bin_slot;
                    if (!bin_hit)
                    begin
                        ovf_reg <= ovf_reg + phist_pkg::CNT_W'(1);
                    end
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (report_reg)
                    begin
                        rd_idx_reg     <= '0;
                        issue_done_reg <= 1'b0;
                        state_reg      <= ST_DUMP;
                    end
                    else if (in_fire)
                    begin
                        state_reg <= ST_BIN;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DUMP:
                begin
                    if (dump_issue)
                    begin
                        pend_idx_reg <= rd_idx_reg;
                        rd_pend_reg  <= 1'b1;
                        if (rd_idx_reg == IW'(REP_N - 1))
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + IW'(1);
                        end
                    end
                    if (dump_load)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    if (issue_done_reg && !rd_pend_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Output register: loaded from the memory, emptied when the beat is taken.
            if (dump_load)
            begin
                out_valid_reg <= 1'b1;
                out_index_reg <= phist_pkg::IDX_W'(pend_idx_reg);
                out_count_reg <= ram_rdata;
                out_ovf_reg   <= ovf_reg;
                out_last_reg  <= (pend_idx_reg == IW'(REP_N - 1));
            end
            else if (rpt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Port drive.
    assign pkt.ready          = in_ready;
    assign rpt.valid          = out_valid_reg;
    assign rpt.bucket_index   = out_index_reg;
    assign rpt.bucket_count   = out_count_reg;
    assign rpt.overflow_count = out_ovf_reg;
    assign rpt.last_bucket    = out_last_reg;

endmodule

`default_nettype wire

// ----- design/phist_ram.sv -----
// Single-port-write, registered-read memory holding the bucket counters.
`default_nettype none

module phist_ram #(
    parameter int DEPTH = phist_pkg::NUM_BUCKETS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire phist_pkg::count_t wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output phist_pkg::count_t      rdata
);

    phist_pkg::count_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/phist_bin.sv -----
// Bucket selection: shifts the time delta and checks it against the bucket count.
`default_nettype none

module phist_bin #(
    parameter int NUM_BUCKETS = phist_pkg::NUM_BUCKETS_DEF,
    parameter int AW          = $clog2(NUM_BUCKETS)
) (
    input  wire phist_pkg::stamp_t delta,
    input  wire phist_pkg::shift_t shift,
    output logic                   hit,
    output logic [AW-1:0]          slot
);

    phist_pkg::stamp_t shifted;

    // The whole shifted word takes part in the compare, so large deltas overflow.
    always_comb
    begin
        shifted = delta >> shift;
        hit     = shifted < phist_pkg::TIME_W'(NUM_BUCKETS);
        slot    = shifted[AW-1:0];
    end

endmodule

`default_nettype wire

// ----- design/phist_checker.sv -----
// Port-level checker of the interarrival histogram and its bind to the top level.
`default_nettype none

`include "packet_interarrival_histogram_assert.svh"

module phist_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire phist_pkg::bucket_idx_t out_index,
    input wire phist_pkg::count_t      out_count,
    input wire phist_pkg::count_t      out_ovf,
    input wire logic                   out_last
);

    logic out_fire;
    logic in_seen;

    assign out_fire = out_valid && out_ready;
    assign in_seen  = in_valid || !in_valid;

    // A stalled report beat holds its payload.
    `PHIST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_index) && $stable(out_count) && $stable(out_ovf) && $stable(out_last), "report beat changed while stalled")

    // No packet is taken in the middle of a report.
    `PHIST_ASSERT_NOW(a_no_pkt_in_report, clk, rst_n, out_valid && !out_last && in_seen, !in_ready, "packet channel ready during a report")

    // Buckets are reported in order within a report.
    `PHIST_ASSERT_NEXT(a_index_step, clk, rst_n, out_fire && !out_last, !out_valid || (out_index == $past(out_index) + phist_pkg::IDX_W'(1)), "bucket index out of order")

    // The overflow count is the same in every beat of a report.
    `PHIST_ASSERT_NEXT(a_ovf_steady, clk, rst_n, out_fire && !out_last, !out_valid || (out_ovf == $past(out_ovf)), "overflow count changed within a report")

    // A new report starts from the first bucket.
    `PHIST_ASSERT_NEXT(a_report_start, clk, rst_n, out_fire && out_last, !out_valid || (out_index == '0), "report did not start at bucket zero")

endmodule

bind packet_interarrival_histogram phist_checker u_phist_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pkt.valid),
    .in_ready  (pkt.ready),
    .out_valid (rpt.valid),
    .out_ready (rpt.ready),
    .out_index (rpt.bucket_index),
    .out_count (rpt.bucket_count),
    .out_ovf   (rpt.overflow_count),
    .out_last  (rpt.last_bucket)
);

`default_nettype wire
